// ----- rtl/tsp_pkg.sv -----
// Shared types and constants for the two-sum pair finder.
// Used by tsp_ctrl, tsp_datapath and two_sum_pair_finder_core; no dependencies.
package tsp_pkg;

   localparam int MAX_LEN = 256;
   localparam int IDX_W   = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   localparam logic [1:0] STATUS_PAIR     = 2'd0;
   localparam logic [1:0] STATUS_NO_PAIR  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [7:0] FALLBACK_EARLIER = 8'd0;
   localparam logic [7:0] FALLBACK_LATER   = 8'd1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_STORE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic accept;
      logic start_scan;
      logic scan;
      logic take_hit;
      logic overflow;
      logic store;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic answered;
      logic full;
      logic empty;
      logic hit;
      logic scan_done;
      logic last;
      logic out_free;
   } stat_type;

endpackage

// ----- rtl/two_sum_pair_finder_core.sv -----
// Top level of the two-sum pair finder: joins tsp_ctrl and tsp_datapath.
// Depends on tsp_pkg, tsp_ctrl and tsp_datapath.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  element_value, first_element, last_element
//   rsp_      out        rsp_valid/rsp_stall  status, earlier_index, later_index
//   csr_      in         csr_wr_en            csr_wr_data (target sum)
//
// A stored element passes through the check, a backward scan of the elements already stored
// (skipped when the store is empty) and the store before the next is accepted; an element
// after a result only passes the check. The entries are read back one per cycle, newest first, and a
// match ends the scan early. A result adds the emit state, in which it waits while the output register
// still holds an earlier result under stall; otherwise it does not block the next transaction.
// Reset clears the control state and the target sum; the store needs no clearing.
module two_sum_pair_finder_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_element_value,
   input  logic               req_first_element,
   input  logic               req_last_element,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_earlier_index,
   output logic [7:0]         rsp_later_index,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data
);

   tsp_pkg::cmd_type  cmd;
   tsp_pkg::stat_type stat;
   logic              idle;

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd),
      .idle      (idle)
   );

   tsp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_element_value (req_element_value),
      .req_first_element (req_first_element),
      .req_last_element  (req_last_element),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_later_index   (rsp_later_index)
   );

   assign req_stall = !idle;

endmodule

// ----- rtl/tsp_datapath.sv -----
// Datapath of the two-sum pair finder: element store, backward scan and result register.
// Depends on tsp_pkg; driven by commands from tsp_ctrl.
module tsp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tsp_pkg::cmd_type    cmd,
   output tsp_pkg::stat_type   stat,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data,
   input  logic signed [31:0]  req_element_value,
   input  logic                req_first_element,
   input  logic                req_last_element,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [7:0]          rsp_earlier_index,
   output logic [7:0]          rsp_later_index
);

   logic [31:0]               mem [tsp_pkg::MAX_LEN];
   logic [31:0]               target_ff;
   logic [31:0]               elem_ff;
   logic                      last_ff;
   logic [32:0]               need_ff;
   logic [tsp_pkg::CNT_W-1:0] count_ff;
   logic                      answered_ff;
   logic [tsp_pkg::CNT_W-1:0] ptr_ff;
   logic                      rd_pending_ff;
   logic [tsp_pkg::IDX_W-1:0] rd_idx_ff;
   logic [31:0]               rd_data_ff;
   logic [1:0]                res_status_ff;
   logic [7:0]                res_earlier_ff;
   logic [7:0]                res_later_ff;
   logic                      rsp_valid_ff;
   logic [1:0]                rsp_status_ff;
   logic [7:0]                rsp_earlier_ff;
   logic [7:0]                rsp_later_ff;
   logic [tsp_pkg::CNT_W-1:0] ptr_dec;
   logic                      match;
   logic                      issue;

   assign ptr_dec = ptr_ff - tsp_pkg::CNT_W'(1);
   assign match   = rd_pending_ff && ({rd_data_ff[31], rd_data_ff} == need_ff);
   assign issue   = cmd.scan && (ptr_ff != '0) && !match;

   assign stat.answered  = answered_ff;
   assign stat.full      = (count_ff == tsp_pkg::CNT_W'(tsp_pkg::MAX_LEN));
   assign stat.empty     = (count_ff == '0);
   assign stat.hit       = match;
   assign stat.scan_done = !rd_pending_ff && (ptr_ff == '0);
   assign stat.last      = last_ff;
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.store && !stat.full) begin
         mem[count_ff[tsp_pkg::IDX_W-1:0]] <= elem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[ptr_dec[tsp_pkg::IDX_W-1:0]];
         rd_idx_ff  <= ptr_dec[tsp_pkg::IDX_W-1:0];
      end
      if (cmd.accept) begin
         elem_ff <= req_element_value;
         last_ff <= req_last_element;
         need_ff <= {target_ff[31], target_ff} - {req_element_value[31], req_element_value};
      end
      if (cmd.take_hit) begin
         res_status_ff  <= tsp_pkg::STATUS_PAIR;
         res_earlier_ff <= 8'(rd_idx_ff);
         res_later_ff   <= count_ff[7:0];
      end else if (cmd.overflow) begin
         res_status_ff  <= tsp_pkg::STATUS_OVERFLOW;
         res_earlier_ff <= 8'd0;
         res_later_ff   <= 8'd0;
      end else if (cmd.store) begin
         res_status_ff  <= tsp_pkg::STATUS_NO_PAIR;
         res_earlier_ff <= tsp_pkg::FALLBACK_EARLIER;
         res_later_ff   <= tsp_pkg::FALLBACK_LATER;
      end
      if (cmd.emit) begin
         rsp_status_ff  <= res_status_ff;
         rsp_earlier_ff <= res_earlier_ff;
         rsp_later_ff   <= res_later_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         count_ff      <= '0;
         answered_ff   <= 1'b0;
         ptr_ff        <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
         if (cmd.accept && req_first_element) begin
            count_ff    <= '0;
            answered_ff <= 1'b0;
         end
         if (cmd.take_hit || cmd.overflow) begin
            answered_ff <= 1'b1;
         end
         if (cmd.store) begin
            count_ff <= count_ff + tsp_pkg::CNT_W'(1);
            if (last_ff) begin
               answered_ff <= 1'b1;
            end
         end
         if (cmd.start_scan) begin
            ptr_ff        <= count_ff;
            rd_pending_ff <= 1'b0;
         end else if (issue) begin
            ptr_ff        <= ptr_dec;
            rd_pending_ff <= 1'b1;
         end else begin
            rd_pending_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_earlier_index = rsp_earlier_ff;
   assign rsp_later_index   = rsp_later_ff;

endmodule

// ----- rtl/tsp_ctrl.sv -----
// Controller of the two-sum pair finder: sequences accept, check, scan, store and emit.
// Depends on tsp_pkg; drives tsp_datapath through the command struct.
module tsp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  tsp_pkg::stat_type  stat,
   output tsp_pkg::cmd_type   cmd,
   output logic               idle
);

   tsp_pkg::state_type state_ff;
   tsp_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         tsp_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = tsp_pkg::ST_CHECK;
            end
         end
         tsp_pkg::ST_CHECK: begin
            if (stat.answered) begin
               state_in = tsp_pkg::ST_IDLE;
            end else if (stat.full) begin
               cmd.overflow = 1'b1;
               state_in     = tsp_pkg::ST_EMIT;
            end else if (stat.empty) begin
               state_in = tsp_pkg::ST_STORE;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = tsp_pkg::ST_SCAN;
            end
         end
         tsp_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = tsp_pkg::ST_EMIT;
            end else if (stat.scan_done) begin
               state_in = tsp_pkg::ST_STORE;
            end
         end
         tsp_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = stat.last ? tsp_pkg::ST_EMIT : tsp_pkg::ST_IDLE;
         end
         tsp_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = tsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == tsp_pkg::ST_IDLE);

endmodule

// ----- test/two_sum_pair_finder_core_tb.sv -----
// Self-checking testbench for two_sum_pair_finder_core: arrays of elements go in
// and an internal two-sum predictor checks every pair, no-pair and overflow result.
// Depends on tsp_pkg and two_sum_pair_finder_core.
module two_sum_pair_finder_core_tb;

   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = tsp_pkg::MAX_LEN + 40;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 135;
   localparam longint ELEM_MIN = -64'sd2147483648;
   localparam longint ELEM_MAX = 64'sd2147483647;

   typedef struct packed {
      logic signed [31:0] value;
      logic               first_mark;
      logic               last_mark;
   } element_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] earlier;
      logic [7:0] later;
   } pair_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_element_value = '0;
   logic               req_first_element = 1'b0;
   logic               req_last_element = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_earlier_index;
   logic [7:0]         rsp_later_index;
   logic               csr_wr_en = 1'b0;
   logic [31:0]        csr_wr_data = '0;

   element_item_type   pending_elements[$];
   pair_result_type    expected_pairs[$];

   logic signed [31:0] stored_elems[tsp_pkg::MAX_LEN];
   int                 stored_count = 0;
   bit                 array_done = 1'b0;
   logic signed [31:0] target_model = '0;

   longint             stim_target = 0;
   int                 items_queued = 0;
   int                 sender_idle_pct = 0;
   int                 stall_pct = 0;
   int                 mismatches = 0;
   int                 quiet_cycles = 0;

   two_sum_pair_finder_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .req_first_element (req_first_element),
      .req_last_element  (req_last_element),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_earlier_index (rsp_earlier_index),
      .rsp_later_index   (rsp_later_index),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one accepted element to the predicted search state.
   function automatic bit predict_pair(input element_item_type it,
                                       output pair_result_type res);
      longint need;
      int     hit_at;
      res = '0;
      if (it.first_mark) begin
         stored_count = 0;
         array_done   = 1'b0;
      end
      if (array_done) return 1'b0;
      if (stored_count >= tsp_pkg::MAX_LEN) begin
         array_done  = 1'b1;
         res.status  = tsp_pkg::STATUS_OVERFLOW;
         res.earlier = 8'd0;
         res.later   = 8'd0;
         return 1'b1;
      end
      need   = longint'(target_model) - longint'(it.value);
      hit_at = -1;
      for (int i = 0; i < stored_count; i++) begin
         if (longint'(stored_elems[i]) == need) hit_at = i;
      end
      if (hit_at >= 0) begin
         array_done  = 1'b1;
         res.status  = tsp_pkg::STATUS_PAIR;
         res.earlier = hit_at[7:0];
         res.later   = stored_count[7:0];
         return 1'b1;
      end
      stored_elems[stored_count] = it.value;
      stored_count++;
      if (it.last_mark) begin
         array_done  = 1'b1;
         res.status  = tsp_pkg::STATUS_NO_PAIR;
         res.earlier = tsp_pkg::FALLBACK_EARLIER;
         res.later   = tsp_pkg::FALLBACK_LATER;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(3))
         0, 1: return $urandom;
         2: return $urandom_range(40) - 20;
         default: begin
            case ($urandom_range(4))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return -32'sd1;
               3: return 32'sd0;
               default: return 32'sd1;
            endcase
         end
      endcase
   endfunction

   // Random array content in which many elements complete or repeat an earlier one.
   task automatic gen_array(input int len, input bit first_mark, input bit last_mark,
                            input bit noisy);
      logic signed [31:0] vals[$];
      logic signed [31:0] v;
      element_item_type   it;
      longint             need;
      int                 k;
      int                 r;
      for (int n = 0; n < len; n++) begin
         r = $urandom_range(99);
         v = rand_value();
         if (vals.size() != 0 && r < 45) begin
            k    = $urandom_range(vals.size() - 1);
            need = stim_target - longint'(vals[k]);
            if (r < 35) begin
               if (need >= ELEM_MIN && need <= ELEM_MAX) v = need[31:0];
            end else begin
               v = vals[k];
            end
         end
         vals.push_back(v);
         it.value      = v;
         it.first_mark = noisy ? 1'($urandom_range(1)) : (first_mark && n == 0);
         it.last_mark  = noisy ? ($urandom_range(3) == 0) : (last_mark && n == len - 1);
         pending_elements.push_back(it);
      end
      items_queued += len;
   endtask

   // Long array whose elements all exceed half the target, so no two of them pair up;
   // optionally the final element is the partner of one of them.
   task automatic gen_spread_array(input int len, input bit last_mark, input bit end_pair);
      logic signed [31:0] vals[$];
      element_item_type   it;
      longint             lo;
      longint             need;
      lo = (stim_target >>> 1) + 1;
      for (int n = 0; n < len; n++) begin
         it.value = 32'(lo + (longint'($urandom) % (ELEM_MAX - lo + 1)));
         if (end_pair && n == len - 1) begin
            need = stim_target - longint'(vals[$urandom_range(vals.size() - 1)]);
            if (need >= ELEM_MIN && need <= ELEM_MAX) it.value = need[31:0];
         end
         vals.push_back(it.value);
         it.first_mark = (n == 0);
         it.last_mark  = last_mark && n == len - 1;
         pending_elements.push_back(it);
      end
      items_queued += len;
   endtask

   task automatic settle();
      while (pending_elements.size() != 0 || req_valid || expected_pairs.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin : element_driver
      element_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_elements.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            nxt = pending_elements.pop_front();
            req_valid         <= 1'b1;
            req_element_value <= nxt.value;
            req_first_element <= nxt.first_mark;
            req_last_element  <= nxt.last_mark;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : pair_monitor
      element_item_type acc;
      pair_result_type  got;
      pair_result_type  want;
      if (reset) begin
         stored_count = 0;
         array_done   = 1'b0;
         target_model = '0;
      end else begin
         if (csr_wr_en) target_model = csr_wr_data;
         if (req_valid && !req_stall) begin
            acc.value      = req_element_value;
            acc.first_mark = req_first_element;
            acc.last_mark  = req_last_element;
            if (predict_pair(acc, want)) expected_pairs.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.status  = rsp_status;
            got.earlier = rsp_earlier_index;
            got.later   = rsp_later_index;
            if (expected_pairs.size() == 0) begin
               $error("unexpected result transaction: status %0d, earlier %0d, later %0d",
                      got.status, got.earlier, got.later);
               mismatches++;
            end else begin
               want = expected_pairs.pop_front();
               if (got.status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.earlier !== want.earlier) begin
                  $error("rsp_earlier_index: expected %0d, got %0d", want.earlier, got.earlier);
                  mismatches++;
               end
               if (got.later !== want.later) begin
                  $error("rsp_later_index: expected %0d, got %0d", want.later, got.later);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("two_sum_pair_finder_core regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic signed [31:0] phase_targets[PHASE_COUNT];
      int                 r;
      phase_targets = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1,
                        32'sd0, 32'sd0, 32'sd0};
      for (int p = 5; p < PHASE_COUNT; p++) phase_targets[p] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first elements carry no first mark, so the stream opens an array by itself.
      // The target is still at its reset value of zero here.
      pending_elements.push_back('{32'sd5, 1'b0, 1'b0});
      pending_elements.push_back('{-32'sd5, 1'b0, 1'b0});
      pending_elements.push_back('{32'sd7, 1'b0, 1'b1});
      pending_elements.push_back('{32'sh8000_0000, 1'b1, 1'b0});
      pending_elements.push_back('{32'sh7FFF_FFFF, 1'b0, 1'b0});
      pending_elements.push_back('{32'sh8000_0000, 1'b0, 1'b0});
      pending_elements.push_back('{32'sd0, 1'b0, 1'b1});
      pending_elements.push_back('{32'sd4, 1'b1, 1'b0});
      pending_elements.push_back('{32'sd4, 1'b0, 1'b0});
      pending_elements.push_back('{-32'sd4, 1'b0, 1'b0});
      pending_elements.push_back('{32'sd9, 1'b0, 1'b1});
      pending_elements.push_back('{32'sd0, 1'b1, 1'b1});
      pending_elements.push_back('{32'sd0, 1'b1, 1'b0});
      pending_elements.push_back('{32'sd0, 1'b0, 1'b1});
      pending_elements.push_back('{32'sh7FFF_FFFF, 1'b1, 1'b0});
      pending_elements.push_back('{32'sh7FFF_FFFF, 1'b0, 1'b0});
      pending_elements.push_back('{-32'sd2147483647, 1'b0, 1'b1});
      pending_elements.push_back('{-32'sd1, 1'b0, 1'b0});
      pending_elements.push_back('{32'sd1, 1'b1, 1'b1});

      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 76; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 76; end
            default: begin sender_idle_pct = 36; stall_pct = 36; end
         endcase
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_targets[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         stim_target = longint'(phase_targets[p]);
         @(negedge clock);

         items_queued = 0;
         case (p)
            1: gen_spread_array(tsp_pkg::MAX_LEN + 4, 1'b1, 1'b0);
            2: gen_spread_array(tsp_pkg::MAX_LEN, 1'b1, 1'b0);
            4: gen_spread_array(tsp_pkg::MAX_LEN, 1'b1, 1'b1);
            default: ;
         endcase
         items_queued = 0;
         while (items_queued < PHASE_ITEMS) begin
            r = $urandom_range(99);
            if (r < 70)
               gen_array(($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                         1'b1, 1'b1, 1'b0);
            else if (r < 80)
               gen_array($urandom_range(1, 8), 1'b1, 1'b0, 1'b0);
            else if (r < 88)
               gen_array($urandom_range(1, 6), 1'b0, 1'($urandom_range(1)), 1'b0);
            else
               gen_array($urandom_range(1, 4), 1'b0, 1'b0, 1'b1);
         end
      end
      settle();

      if (mismatches == 0 && expected_pairs.size() == 0) begin
         $display("two_sum_pair_finder_core regression: pass");
      end else begin
         $display("two_sum_pair_finder_core regression: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tsp_pkg.sv
rtl/tsp_datapath.sv
rtl/tsp_ctrl.sv
rtl/two_sum_pair_finder_core.sv
test/two_sum_pair_finder_core_tb.sv
